>>> rtl/core/int16_to_decimal_ascii_unit_assert.svh
// Assertion macros shared by the i2d modules.
`ifndef INT16_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define INT16_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define I2D_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define I2D_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/i2d_pkg.sv
package i2d_pkg;

  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned NUM_SPLITS = 4;

  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_MINUS = 7'd45;

  // Divisor per split stage, most significant first.
  localparam int unsigned DIV_TBL [NUM_SPLITS] = '{10000, 1000, 100, 10};

  // In-flight item inside the digit pipeline.
  typedef struct packed {
    logic            neg;
    logic [2:0]      ndig;
    logic [15:0]     rest;
    logic [4:1][3:0] digit;
  } i2d_item_t;

  // Finished word handed to the serializer; digit[0] is the units digit.
  typedef struct packed {
    logic            neg;
    logic [2:0]      ndig;
    logic [4:0][3:0] digit;
  } i2d_word_t;

  function automatic logic [3:0] digit_of(input logic [15:0] r, input int unsigned k);
    logic [3:0] d;
    d = '0;
    for (int unsigned j = 1; j <= 9; j++) begin
      if ({1'b0, r} >= 17'(j * DIV_TBL[k])) begin
        d = 4'(j);
      end
    end
    return d;
  endfunction

  function automatic logic [15:0] rest_of(input logic [15:0] r, input logic [3:0] d,
                                          input int unsigned k);
    return r - 16'(int'(d) * DIV_TBL[k]);
  endfunction

  // Number of decimal digits of a magnitude (1..5).
  function automatic logic [2:0] ndig_of(input logic [15:0] m);
    return 3'd1 + 3'(m >= 16'd10) + 3'(m >= 16'd100) + 3'(m >= 16'd1000)
         + 3'(m >= 16'd10000);
  endfunction

endpackage

>>> rtl/core/i2d_digit_pipe.sv
module i2d_digit_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       in_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2d_pkg::i2d_word_t out_word_o
);

  localparam int unsigned LastStage = i2d_pkg::NUM_STAGES - 1;

  logic [LastStage:0] valid_q;
  logic [LastStage:0] rdy;
  i2d_pkg::i2d_item_t stage_q [i2d_pkg::NUM_STAGES];
  i2d_pkg::i2d_item_t split_d [i2d_pkg::NUM_SPLITS];
  i2d_pkg::i2d_item_t entry_d;

  // A slot can load when it is empty or its occupant moves on.
  always_comb begin
    rdy[LastStage] = !valid_q[LastStage] || out_ready_i;
    for (int k = LastStage - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    entry_d       = '0;
    entry_d.neg   = in_value_i[15];
    entry_d.rest  = in_value_i[15] ? (~in_value_i + 16'd1) : in_value_i;
  end

  for (genvar k = 0; k < i2d_pkg::NUM_SPLITS; k++) begin : g_split
    localparam int unsigned DigIdx = i2d_pkg::NUM_SPLITS - k;
    logic [3:0] dig;
    assign dig = i2d_pkg::digit_of(stage_q[k].rest, k);
    always_comb begin
      split_d[k]               = stage_q[k];
      split_d[k].digit[DigIdx] = dig;
      split_d[k].rest          = i2d_pkg::rest_of(stage_q[k].rest, dig, k);
      if (k == 0) begin
        split_d[k].ndig = i2d_pkg::ndig_of(stage_q[k].rest);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= LastStage; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      stage_q[0] <= entry_d;
    end
    for (int k = 1; k <= LastStage; k++) begin
      if (rdy[k] && valid_q[k-1]) begin
        stage_q[k] <= split_d[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[LastStage];

  always_comb begin
    out_word_o.neg      = stage_q[LastStage].neg;
    out_word_o.ndig     = stage_q[LastStage].ndig;
    out_word_o.digit    = {stage_q[LastStage].digit, stage_q[LastStage].rest[3:0]};
  end

  `include "int16_to_decimal_ascii_unit_assert.svh"

  `I2D_ASSERT_NEXT(a_tail_holds, clk_i, rst_ni,
                   valid_q[LastStage] && !out_ready_i,
                   valid_q[LastStage] && $stable(stage_q[LastStage]),
                   "stalled tail item changed")
  `I2D_ASSERT_NOW(a_units_range, clk_i, rst_ni, valid_q[LastStage],
                  stage_q[LastStage].rest < 16'd10, "units remainder out of range")
  `I2D_ASSERT_NOW(a_ndig_range, clk_i, rst_ni, valid_q[1],
                  stage_q[1].ndig >= 3'd1 && stage_q[1].ndig <= 3'd5,
                  "digit count out of range")

endmodule

>>> rtl/core/i2d_serializer.sv
module i2d_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2d_pkg::i2d_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_char_o,
  output logic              out_last_o,
  output logic [2:0]        out_len_o
);

  logic              busy_q;
  logic              sign_q;
  logic [2:0]        dsel_q;
  i2d_pkg::i2d_word_t word_q;
  logic              last;
  logic              load;
  logic              take;
  logic [2:0]        len;

  assign last = !sign_q && (dsel_q == 3'd0);
  assign take = busy_q && out_ready_i;
  // Next word loads in the same cycle the final character leaves.
  assign in_ready_o = !busy_q || (out_ready_i && last);
  assign load = in_valid_i && in_ready_o;
  assign len  = {2'b00, word_q.neg} + word_q.ndig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      dsel_q <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        sign_q <= in_word_i.neg;
        dsel_q <= in_word_i.ndig - 3'd1;
      end else if (take && last) begin
        busy_q <= 1'b0;
      end else if (take) begin
        if (sign_q) begin
          sign_q <= 1'b0;
        end else begin
          dsel_q <= dsel_q - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign out_valid_o = busy_q;
  assign out_char_o  = sign_q ? i2d_pkg::CH_MINUS
                              : i2d_pkg::CH_ZERO + {3'b000, word_q.digit[dsel_q]};
  assign out_last_o  = last;
  assign out_len_o   = last ? len : 3'd0;

  `include "int16_to_decimal_ascii_unit_assert.svh"

  `I2D_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, take && !last, busy_q,
                   "character run ended early")
  `I2D_ASSERT_NOW(a_dsel_range, clk_i, rst_ni, busy_q, dsel_q <= 3'd4,
                  "digit select out of range")
  `I2D_ASSERT_NOW(a_len_range, clk_i, rst_ni, busy_q && last,
                  len >= 3'd1 && len <= 3'd6, "text length out of range")

endmodule

>>> rtl/core/int16_to_decimal_ascii_unit.sv
// Channel   Dir  Bits                               Meaning
// s_axis    in   tdata[15:0] value                  signed number, one per request
// m_axis    out  tdata[6:0] character,              one ASCII char per request,
//                tdata[9:7] total_length, tlast     most significant first
//
// A value passes five register stages (magnitude, then one decimal digit each) and
// the serializer register, from which its first character is offered. Output rate is
// one character per cycle while m_axis_tready is high; a value holds the serializer
// for as many characters as its text length (1..6), which sets the sustained input rate.
// Reset clears all valid bits and the serializer's control state; data registers are not reset.
// m_axis_tready low freezes the serializer and backs up the digit stages, losing nothing.
module int16_to_decimal_ascii_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [i2d_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [15:0] value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [i2d_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // [6:0] character, [9:7] total_length
  output logic                             m_axis_tlast
);

  logic               word_valid;
  logic               word_ready;
  i2d_pkg::i2d_word_t word;
  logic [6:0]         out_char;
  logic [2:0]         out_len;

  i2d_digit_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .out_valid_o (word_valid),
    .out_ready_i (word_ready),
    .out_word_o  (word)
  );

  i2d_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (word_valid),
    .in_ready_o  (word_ready),
    .in_word_i   (word),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast),
    .out_len_o   (out_len)
  );

  assign m_axis_tdata = {6'b000000, out_len, out_char};

endmodule

>>> dv/tb.sv
module tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_ITEMS = 250;

  class char_scoreboard;
    typedef struct packed {
      logic [6:0] ch;
      logic       last;
      logic [2:0] len;
    } char_t;

    char_t       expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Formats one accepted value into the characters the block should emit.
    function void note_value(logic [15:0] value);
      logic [16:0] mag;
      logic [6:0]  text[$];
      int unsigned rest;
      char_t       c;
      if (value[15]) begin
        mag = 17'h10000 - {1'b0, value};
        text.push_back(i2d_pkg::CH_MINUS);
      end else begin
        mag = {1'b0, value};
      end
      rest = 32'(mag);
      if (mag >= 10000) begin
        text.push_back(i2d_pkg::CH_ZERO + 7'(rest / 10000));
        rest = rest % 10000;
      end
      if (mag >= 1000) begin
        text.push_back(i2d_pkg::CH_ZERO + 7'(rest / 1000));
        rest = rest % 1000;
      end
      if (mag >= 100) begin
        text.push_back(i2d_pkg::CH_ZERO + 7'(rest / 100));
        rest = rest % 100;
      end
      if (mag >= 10) begin
        text.push_back(i2d_pkg::CH_ZERO + 7'(rest / 10));
      end
      text.push_back(i2d_pkg::CH_ZERO + 7'(rest % 10));
      for (int i = 0; i < text.size(); i++) begin
        c.ch   = text[i];
        c.last = (i == text.size() - 1);
        c.len  = c.last ? 3'(text.size()) : 3'd0;
        expected_q.push_back(c);
      end
    endfunction

    function void check_char(logic [15:0] tdata, logic tlast);
      char_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected character: expected none actual %0d", $time, tdata[6:0]);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (tdata[6:0] !== e.ch) begin
        $display("%0t character mismatch: expected %0d actual %0d", $time, e.ch, tdata[6:0]);
        errors++;
      end
      if (tlast !== e.last) begin
        $display("%0t tlast mismatch: expected %0b actual %0b", $time, e.last, tlast);
        errors++;
      end
      if (tdata[9:7] !== e.len) begin
        $display("%0t total_length mismatch: expected %0d actual %0d", $time, e.len,
                 tdata[9:7]);
        errors++;
      end
      if (tdata[15:10] !== 6'd0) begin
        $display("%0t tdata padding mismatch: expected 0 actual %0h", $time, tdata[15:10]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  char_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    cycle_cnt;

  int directed_vals [] = '{0, 1, -1, 9, 10, -10, 99, 100, -100, 999, 1000, -1000, 9999,
                           10000, -9999, -10000, 32767, -32768, -32767, 12345, -23456,
                           21845, -21846, 5, -7};

  int16_to_decimal_ascii_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_cnt);
      $display("tb failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_value(input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do begin
      @(posedge clk_i);
    end while (!(s_axis_tvalid && s_axis_tready));
    sb.note_value(value);
    @(negedge clk_i);
  endtask

  // Mix of full-range values, values of a chosen digit count, and decade edges.
  function automatic logic [15:0] pick_value();
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    int          mag;
    int unsigned decade;
    case ($urandom_range(3))
      0, 3: begin
        return 16'($urandom);
      end
      1: begin
        ndig = $urandom_range(1, 5);
        lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
        hi   = (ndig == 5) ? 32767 : 10 ** ndig - 1;
        mag  = $urandom_range(hi, lo);
      end
      default: begin
        decade = 10 ** $urandom_range(1, 4);
        mag    = decade + $urandom_range(2) - 1;
      end
    endcase
    return $urandom_range(1) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    sb            = new();
    cycle_cnt     = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    m_axis_tready = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 84;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_vals[i]) begin
      send_value(16'(directed_vals[i]));
    end
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
      send_value(pick_value());
    end

    // hold off the sender until the pipeline has fully drained
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait_drained();

    send_idle_pct = 84;
    recv_idle_pct = 10;
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
      send_value(pick_value());
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++) begin
      send_value(pick_value());
    end
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);

    wait_drained();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      if (sb.pending() != 0) begin
        $display("%0t missing characters: expected %0d more actual 0", $time, sb.pending());
      end
      $display("tb failed");
    end
    $finish;
  end

endmodule
